@@ hw/rtl/krt_pkg.sv @@
// Shared types and constants of the keyed record table.
// Depends on nothing; the sequencer, the top level and the testbench import it.
package krt_pkg;

	localparam int TABLE_DEPTH = 128;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int FILL_W      = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 32;
	localparam int PAY_W       = 64;
	localparam int HELD_W      = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_UPDATE = 2'd2,
		OP_DELETE = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISSING = 2'd2
	} status_e_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_e_t;

	typedef struct packed {
		op_e_t                    operation;
		logic signed [KEY_W-1:0]  key;
		logic [PAY_W-1:0]         payload;
	} req_t;

	typedef struct packed {
		status_e_t                status;
		logic [PAY_W-1:0]         found_payload;
		logic [HELD_W-1:0]        entries_held;
	} rsp_t;

	// Command from the sequencer to the key and payload memories.
	typedef struct packed {
		logic                     rd_en;
		logic [IDX_W-1:0]         rd_addr;
		logic                     wr_key_en;
		logic                     wr_pay_en;
		logic [IDX_W-1:0]         wr_addr;
		logic [KEY_W-1:0]         wr_key;
		logic [PAY_W-1:0]         wr_pay;
	} mem_cmd_t;

endpackage

@@ hw/rtl/krt_ram.sv @@
// Generic single-clock memory with one write port and one registered read port.
// Depends on nothing.
module krt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/krt_seq.sv @@
// Sequencer of the keyed record table: insert, scan, update and shift-down delete.
// Depends on krt_pkg; drives the key and payload memories through mem_cmd_t.
module krt_seq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  krt_pkg::req_t                req,
	input  logic                         rsp_free,
	output logic                         rsp_load,
	output krt_pkg::rsp_t                rsp_next,
	output krt_pkg::mem_cmd_t            mem_cmd,
	input  logic [krt_pkg::KEY_W-1:0]    key_rd,
	input  logic [krt_pkg::PAY_W-1:0]    pay_rd
);
	import krt_pkg::*;

	state_e_t                state_q, state_d;
	op_e_t                   op_q;
	logic [KEY_W-1:0]        key_q;
	logic [PAY_W-1:0]        pay_q;
	logic [FILL_W-1:0]       fill_q;
	logic [FILL_W-1:0]       idx_q;
	logic                    pend_s1;
	logic [IDX_W-1:0]        addr_s1;
	status_e_t               status_q;
	logic [PAY_W-1:0]        found_q;

	logic                    accept;
	logic                    full;
	logic                    issue;
	logic                    hit;
	logic [FILL_W-1:0]       addr_ext;
	logic [FILL_W+HELD_W-1:0] held_ext;

	assign accept   = req_valid && !req_stall;
	assign full     = (fill_q == FILL_W'(TABLE_DEPTH));
	assign issue    = (idx_q < fill_q);
	assign hit      = pend_s1 && (key_rd == key_q);
	assign addr_ext = FILL_W'(addr_s1);
	assign held_ext = {{HELD_W{1'b0}}, fill_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (op_q == OP_INSERT) state_d = S_RESP;
				else state_d = S_SCAN;
			end
			S_SCAN: begin
				if (hit) begin
					if (op_q == OP_DELETE) state_d = S_SHIFT;
					else state_d = S_RESP;
				end else if (!issue && !pend_s1) begin
					state_d = S_RESP;
				end
			end
			S_SHIFT: begin
				if (!issue && !pend_s1) state_d = S_RESP;
			end
			S_RESP: begin
				if (rsp_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs and memory commands.
	always_comb begin
		req_stall         = (state_q != S_IDLE);
		rsp_load          = (state_q == S_RESP) && rsp_free;
		rsp_next.status        = status_q;
		rsp_next.found_payload = found_q;
		rsp_next.entries_held  = held_ext[HELD_W-1:0];
		mem_cmd.rd_en     = 1'b0;
		mem_cmd.rd_addr   = idx_q[IDX_W-1:0];
		mem_cmd.wr_key_en = 1'b0;
		mem_cmd.wr_pay_en = 1'b0;
		mem_cmd.wr_addr   = addr_s1;
		mem_cmd.wr_key    = key_rd;
		mem_cmd.wr_pay    = pay_rd;
		unique case (state_q)
			S_EXEC: begin
				if (op_q == OP_INSERT && !full) begin
					mem_cmd.wr_key_en = 1'b1;
					mem_cmd.wr_pay_en = 1'b1;
					mem_cmd.wr_addr   = fill_q[IDX_W-1:0];
					mem_cmd.wr_key    = key_q;
					mem_cmd.wr_pay    = pay_q;
				end
			end
			S_SCAN: begin
				mem_cmd.rd_en = issue && !hit;
				if (hit && op_q == OP_UPDATE) begin
					mem_cmd.wr_pay_en = 1'b1;
					mem_cmd.wr_pay    = pay_q;
				end
			end
			S_SHIFT: begin
				mem_cmd.rd_en     = issue;
				mem_cmd.wr_key_en = pend_s1;
				mem_cmd.wr_pay_en = pend_s1;
			end
			S_IDLE, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_EXEC: begin
					if (op_q == OP_INSERT && !full) fill_q <= fill_q + 1'b1;
					pend_s1 <= 1'b0;
				end
				S_SCAN: begin
					pend_s1 <= issue && !hit;
				end
				S_SHIFT: begin
					pend_s1 <= issue;
					if (!issue && !pend_s1) fill_q <= fill_q - 1'b1;
				end
				S_IDLE, S_RESP: begin
					pend_s1 <= 1'b0;
				end
				default: begin
					pend_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Request and datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q  <= req.operation;
					key_q <= req.key;
					pay_q <= req.payload;
				end
			end
			S_EXEC: begin
				idx_q    <= '0;
				found_q  <= '0;
				status_q <= (op_q == OP_INSERT && full) ? ST_FULL : ST_DONE;
			end
			S_SCAN: begin
				if (hit) begin
					if (op_q == OP_LOOKUP) found_q <= pay_rd;
					// The shift starts with the record just above the match.
					idx_q <= addr_ext + 1'b1;
				end else begin
					if (issue) begin
						idx_q   <= idx_q + 1'b1;
						addr_s1 <= idx_q[IDX_W-1:0];
					end else if (!pend_s1) begin
						status_q <= ST_MISSING;
					end
				end
			end
			S_SHIFT: begin
				if (issue) begin
					idx_q   <= idx_q + 1'b1;
					// Data read from slot i lands in slot i-1.
					addr_s1 <= idx_q[IDX_W-1:0] - 1'b1;
				end
			end
			S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(TABLE_DEPTH))
		else $error("record count above table depth");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && pend_s1) |-> (addr_ext < fill_q))
		else $error("scan compared a slot beyond the held records");

	a_shift_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && pend_s1) |-> (addr_ext < idx_q))
		else $error("shift write overtook its read");

	a_rsp_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after a response");

endmodule

@@ hw/rtl/keyed_record_table.sv @@
// Keyed record table: a packed, insertion-ordered table of key/payload records.
// An insert writes the next free slot unless the table is full; lookup, update and delete scan
// the held records from slot zero, and a delete then shifts every record above the match down.
// One request is handled at a time, the next taken as the response shows; the single read port
// walks one slot per cycle. Reset empties the table at once.
module keyed_record_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  krt_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output krt_pkg::rsp_t  rsp
);
	import krt_pkg::*;

	mem_cmd_t          mem_cmd;
	logic [KEY_W-1:0]  key_rd;
	logic [PAY_W-1:0]  pay_rd;
	logic              rsp_free;
	logic              rsp_load;
	rsp_t              rsp_next;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	// The sequencer owns the request side and the record count. It reads and
	// writes the two memories below through one command bundle.
	krt_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_free  (rsp_free),
		.rsp_load  (rsp_load),
		.rsp_next  (rsp_next),
		.mem_cmd   (mem_cmd),
		.key_rd    (key_rd),
		.pay_rd    (pay_rd)
	);

	// Keys and payloads live in separate memories that share one address stream,
	// so a key compare and its payload arrive in the same cycle. Update writes
	// only the payload memory.
	krt_ram #(
		.WIDTH (KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk     (clk),
		.rd_en   (mem_cmd.rd_en),
		.rd_addr (mem_cmd.rd_addr),
		.rd_data (key_rd),
		.wr_en   (mem_cmd.wr_key_en),
		.wr_addr (mem_cmd.wr_addr),
		.wr_data (mem_cmd.wr_key)
	);

	krt_ram #(
		.WIDTH (PAY_W),
		.DEPTH (TABLE_DEPTH)
	) u_pay_ram (
		.clk     (clk),
		.rd_en   (mem_cmd.rd_en),
		.rd_addr (mem_cmd.rd_addr),
		.rd_data (pay_rd),
		.wr_en   (mem_cmd.wr_pay_en),
		.wr_addr (mem_cmd.wr_addr),
		.wr_data (mem_cmd.wr_pay)
	);

	// Response register. The sequencer may take the next request while a
	// finished response still waits here; it only holds its own result back
	// until this register is empty or is being emptied in the same cycle.
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A response is only loaded into a register that is free to take it.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_load |-> (!rsp_valid_q || !rsp_stall))
		else $error("response register overwritten while held");

	// A stalled response keeps its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_stall) |=> (rsp_valid_q && $stable(rsp_q)))
		else $error("stalled response changed");

	// Memory writes happen only while a request is being processed.
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_cmd.wr_key_en || mem_cmd.wr_pay_en) |-> req_stall)
		else $error("memory written while idle");

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench of keyed_record_table: directed and random requests against a
// behavioral table model kept inside this file. Depends only on krt_pkg and the RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import krt_pkg::*;

	// Generous bound on the whole run. The slowest correct run is about 960 requests, each
	// scanning at most the whole table, plus random gaps and stalls.
	localparam int CYCLE_LIMIT = 1000000;

	logic  clk;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	keyed_record_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Our own copy of the table. Only slots below held_count are meaningful.
	logic signed [KEY_W-1:0] held_keys [TABLE_DEPTH];
	logic [PAY_W-1:0]        held_pay  [TABLE_DEPTH];
	int                      held_count = 0;

	// Answers predicted for accepted requests, oldest first.
	rsp_t pending_answers[$];

	int error_count = 0;
	int cycle_count = 0;
	int gap_pct     = 0;	// chance per cycle that the sender holds back
	int stall_pct   = 0;	// chance per cycle that the receiver stalls

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// The receiver decides its stall on the falling edge so that it is stable at the
	// rising edge where the handshake is judged.
	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// Lowest slot holding the key, or -1 when no held record carries it.
	function automatic int find_slot(input logic signed [KEY_W-1:0] k);
		int i;
		for (i = 0; i < held_count; i++) begin
			if (held_keys[i] == k)
				return i;
		end
		return -1;
	endfunction

	// Applies one request to our table copy and returns the answer the block must give.
	function automatic rsp_t apply_to_table(input req_t r);
		rsp_t a;
		int   slot;
		int   j;
		a.status        = ST_DONE;
		a.found_payload = '0;
		if (r.operation == OP_INSERT) begin
			if (held_count >= TABLE_DEPTH) begin
				a.status = ST_FULL;
			end else begin
				held_keys[held_count] = r.key;
				held_pay[held_count]  = r.payload;
				held_count++;
			end
		end else begin
			slot = find_slot(r.key);
			if (slot < 0) begin
				a.status = ST_MISSING;
			end else begin
				case (r.operation)
					OP_LOOKUP: begin
						a.found_payload = held_pay[slot];
					end
					OP_UPDATE: begin
						held_pay[slot] = r.payload;
					end
					default: begin
						// Delete closes the gap so that insertion order is kept.
						for (j = slot; j < held_count - 1; j++) begin
							held_keys[j] = held_keys[j + 1];
							held_pay[j]  = held_pay[j + 1];
						end
						held_count--;
					end
				endcase
			end
		end
		a.entries_held = HELD_W'(held_count);
		return a;
	endfunction

	// Each accepted answer is checked against the oldest prediction.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_answers.size() == 0) begin
				error_count++;
				$display("%0t: answer with none expected: status %0d payload %h held %0d",
					$time, rsp.status, rsp.found_payload, rsp.entries_held);
			end else begin
				want = pending_answers.pop_front();
				if (rsp.status !== want.status) begin
					error_count++;
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
				end
				if (rsp.found_payload !== want.found_payload) begin
					error_count++;
					$display("%0t: found_payload expected %h actual %h",
						$time, want.found_payload, rsp.found_payload);
				end
				if (rsp.entries_held !== want.entries_held) begin
					error_count++;
					$display("%0t: entries_held expected %0d actual %0d",
						$time, want.entries_held, rsp.entries_held);
				end
			end
		end
	end

	// Sends one request. Valid is left high after acceptance; the next send either
	// replaces the request or drops valid for a gap, so valid gets one update per edge.
	task automatic send_request(input op_e_t op, input logic signed [KEY_W-1:0] k,
			input logic [PAY_W-1:0] data);
		req_t r;
		r.operation = op;
		r.key       = k;
		r.payload   = data;
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			req_valid <= 1'b0;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req       <= r;
		do
			@(posedge clk);
		while (req_stall);
		pending_answers.push_back(apply_to_table(r));
	endtask

	// Drops valid and holds off until every predicted answer has come back.
	task automatic wait_drained();
		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [PAY_W-1:0] random_payload();
		return {$urandom, $urandom};
	endfunction

	// Mostly keys already held, so that hits are common; a narrow band of small keys gives
	// duplicates and near misses; the rest are full-width random keys.
	function automatic logic signed [KEY_W-1:0] pick_key();
		int roll;
		roll = $urandom_range(99);
		if (held_count > 0 && roll < 55)
			return held_keys[$urandom_range(held_count - 1)];
		if (roll < 80)
			return KEY_W'(int'($urandom_range(15)) - 8);
		return $urandom;
	endfunction

	// Lookup, update and delete on an empty table all miss.
	task automatic test_empty_table();
		send_request(OP_LOOKUP, 32'sd0, random_payload());
		send_request(OP_UPDATE, 32'sd5, random_payload());
		send_request(OP_DELETE, -32'sd1, random_payload());
	endtask

	// Extreme keys and payloads, all operations on key -1, and deletes at both ends.
	task automatic test_key_extremes();
		send_request(OP_INSERT, 32'sh8000_0000, 64'h0);
		send_request(OP_INSERT, 32'sh7fff_ffff, '1);
		send_request(OP_INSERT, 32'sd0, 64'h5555_5555_5555_5555);
		send_request(OP_INSERT, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa);
		send_request(OP_LOOKUP, 32'sh8000_0000, random_payload());
		send_request(OP_LOOKUP, 32'sh7fff_ffff, random_payload());
		send_request(OP_LOOKUP, -32'sd1, random_payload());
		send_request(OP_UPDATE, -32'sd1, '1);
		send_request(OP_LOOKUP, -32'sd1, random_payload());
		send_request(OP_DELETE, 32'sh8000_0000, random_payload());
		send_request(OP_LOOKUP, 32'sh8000_0000, random_payload());
		send_request(OP_UPDATE, 32'sd42, random_payload());
		send_request(OP_DELETE, -32'sd1, random_payload());
	endtask

	// Duplicate keys: only the lowest slot is looked up, updated or deleted.
	task automatic test_duplicate_keys();
		send_request(OP_INSERT, 32'sd0, 64'h0123_4567_89ab_cdef);
		send_request(OP_LOOKUP, 32'sd0, random_payload());
		send_request(OP_UPDATE, 32'sd0, 64'hfedc_ba98_7654_3210);
		send_request(OP_LOOKUP, 32'sd0, random_payload());
		send_request(OP_DELETE, 32'sd0, random_payload());
		send_request(OP_LOOKUP, 32'sd0, random_payload());
		send_request(OP_DELETE, 32'sd0, random_payload());
		send_request(OP_LOOKUP, 32'sd0, random_payload());
	endtask

	// Fills the table, then tries an insert on a full table, misses that scan every slot
	// and a delete of slot zero that shifts the whole table.
	task automatic test_full_table();
		logic signed [KEY_W-1:0] absent;
		while (held_count < TABLE_DEPTH)
			send_request(OP_INSERT, pick_key(), random_payload());
		send_request(OP_INSERT, 32'sh7fff_ffff, random_payload());
		send_request(OP_LOOKUP, held_keys[TABLE_DEPTH - 1], random_payload());
		do
			absent = $urandom;
		while (find_slot(absent) >= 0);
		send_request(OP_LOOKUP, absent, random_payload());
		send_request(OP_UPDATE, absent, random_payload());
		send_request(OP_DELETE, absent, random_payload());
		send_request(OP_UPDATE, held_keys[TABLE_DEPTH - 1], random_payload());
		send_request(OP_DELETE, held_keys[0], random_payload());
		send_request(OP_INSERT, absent, random_payload());
		send_request(OP_INSERT, pick_key(), random_payload());
	endtask

	// Random traffic under one idling profile: an insert-heavy half that pushes the table
	// toward full, then a delete-heavy half that drains it again.
	task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
		int    n;
		int    roll;
		int    insert_pct;
		int    delete_pct;
		op_e_t op;
		gap_pct   = sender_idle;
		stall_pct = receiver_idle;
		for (n = 0; n < 200; n++) begin
			insert_pct = (n < 100) ? 70 : 15;
			delete_pct = (n < 100) ? 8 : 50;
			roll = $urandom_range(99);
			if (roll < insert_pct)
				op = OP_INSERT;
			else if (roll < insert_pct + delete_pct)
				op = OP_DELETE;
			else if (roll[0])
				op = OP_LOOKUP;
			else
				op = OP_UPDATE;
			send_request(op, pick_key(), random_payload());
		end
		wait_drained();
	endtask

	initial begin
		// Reset is held at the start and released on a falling edge.
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_table();
		test_key_extremes();
		test_duplicate_keys();
		wait_drained();
		test_full_table();
		wait_drained();

		test_random_traffic(0, 0);
		test_random_traffic(47, 0);
		test_random_traffic(0, 47);
		test_random_traffic(19, 19);

		// Give a stray answer time to show up before the verdict.
		repeat (TABLE_DEPTH + 10) @(posedge clk);
		if (error_count == 0 && pending_answers.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/krt_pkg.sv
hw/rtl/krt_ram.sv
hw/rtl/krt_seq.sv
hw/rtl/keyed_record_table.sv
bench/tb_top.sv
